>>> rtl/easdf_pkg.sv
// Shared types and constants for the edge-avoiding search and charge drive controller.
// Used by easdf_div and edge_avoid_search_drive_fsm_top; depends on nothing.
`timescale 1ns / 1ps

package easdf_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SWEEP_PERIOD = 2'd0;
   localparam logic [1:0] CSR_SWEEP_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_SEARCH_TURN  = 2'd2;
   localparam logic [1:0] CSR_SEARCH_GO    = 2'd3;

   localparam int CSR_DATA_W = 16;
   localparam int BUDGET_W   = 24;   // sweep limit times sweep period
   localparam int QUOT_W     = 8;    // the sweep index stays below the sweep limit

   // Reset values of the configuration registers and of the deadline.
   localparam logic [15:0] SWEEP_PERIOD_RST = 16'd500;
   localparam logic [7:0]  SWEEP_LIMIT_RST  = 8'd4;
   localparam logic [15:0] SEARCH_TURN_RST  = 16'd1250;
   localparam logic [15:0] SEARCH_GO_RST    = 16'd250;
   localparam logic [31:0] DEADLINE_RST     = 32'd1000;

   // Servo values.
   localparam logic [7:0] ROT_DIFF = 8'd12;
   localparam logic [7:0] MID_L    = 8'd79;
   localparam logic [7:0] MID_R    = 8'd81;
   localparam logic [7:0] FULL     = 8'd180;
   localparam logic [7:0] STOP     = 8'd0;

   // Edge sensor patterns.
   localparam logic [2:0] EDGE_FL      = 3'd1;
   localparam logic [2:0] EDGE_FR      = 3'd2;
   localparam logic [2:0] EDGE_FRONT   = 3'd3;
   localparam logic [2:0] EDGE_REAR    = 3'h4;
   localparam logic [2:0] EDGE_REAR_FL = 3'h5;
   localparam logic [2:0] EDGE_REAR_FR = 3'h6;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_CHARGE = 2'd1,
      MODE_REFIND = 2'd2,
      MODE_AVOID  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [2:0]  edge_bits;
      logic        target_seen;
   } req_type;

   typedef struct packed {
      logic [7:0] left_drive;
      logic [7:0] right_drive;
      logic       drive_update;
      logic [1:0] mode_code;
   } rsp_type;

   // Drive command held between the sequencer steps.
   typedef struct packed {
      logic [7:0] left;
      logic [7:0] right;
      logic       update;
   } cmd_type;

endpackage

>>> rtl/easdf_div.sv
// Serial restoring divider that finds the parity of the sweep index (elapsed / period).
// Depends on easdf_pkg for widths.
`timescale 1ns / 1ps

module easdf_div
   import easdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [BUDGET_W-1:0] dividend,
   input  logic [15:0]         divisor,
   output logic                done,
   output logic                odd
);

   localparam int CNT_W = $clog2(QUOT_W);

   logic [BUDGET_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                odd_ff, odd_in;
   logic [BUDGET_W-1:0] trial;
   logic                ge;

   // One quotient bit per cycle; the dividend is known to be below divisor * 2^QUOT_W.
   assign trial = BUDGET_W'(divisor) << cnt_ff;
   assign ge    = rem_ff >= trial;

   always_comb begin
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      odd_in  = odd_ff;
      if (start) begin
         rem_in  = dividend;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - trial;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            odd_in  = ge;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      odd_ff <= odd_in;
   end

   assign done = done_ff;
   assign odd  = odd_ff;

endmodule

>>> rtl/edge_avoid_search_drive_fsm_top.sv
// Channel   | direction | handshake          | payload
// req_      | in        | req_valid/req_stall | req_type: now_ms, edge_bits, target_seen
// rsp_      | out       | rsp_valid/rsp_stall | rsp_type: drives, update flag, mode
// csr_      | in        | csr_we              | csr_addr, csr_data
//
// A request passes through the evaluate and finish steps; a refinding tick that has
// used up its sweep budget adds the compare step, and one that needs the sweep index
// adds compare and divide; the serial divider works out one quotient bit per cycle.
// req_stall is high from acceptance until the result is loaded into the output register.
// A result waiting under rsp_stall does not block the next request.
// Reset is synchronous and restores the mode, timers and register defaults.
// Depends on easdf_pkg and easdf_div.
`timescale 1ns / 1ps

module edge_avoid_search_drive_fsm_top
   import easdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_CMP    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } seq_type;

   seq_type              state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [1:0]           phase_ff, phase_in;
   logic [31:0]          deadline_ff, deadline_in;
   logic [31:0]          sweep_start_ff, sweep_start_in;
   logic [15:0]          period_ff;
   logic [7:0]           limit_ff;
   logic [15:0]          turn_ff;
   logic [15:0]          go_ff;
   req_type              req_ff, req_in;
   cmd_type              cmd_ff, cmd_in;
   logic [31:0]          diff_ff, diff_in;
   logic [BUDGET_W-1:0]  budget_ff, budget_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 div_start;
   logic                 div_done;
   logic                 div_odd;
   logic                 any_edge;
   logic [1:0]           phase_next;
   logic [31:0]          turn_deadline;

   easdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_ff[BUDGET_W-1:0]),
      .divisor  (period_ff),
      .done     (div_done),
      .odd      (div_odd)
   );

   assign any_edge      = |req_ff.edge_bits;
   assign phase_next    = phase_ff + 2'd1;
   assign turn_deadline = req_ff.now_ms + 32'(turn_ff);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      deadline_in    = deadline_ff;
      sweep_start_in = sweep_start_ff;
      req_in         = req_ff;
      cmd_in         = cmd_ff;
      diff_in        = diff_ff;
      budget_in      = budget_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      div_start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd_in   = '{left: STOP, right: STOP, update: 1'b0};
            state_in = ST_FINISH;
            unique case (mode_ff)
               MODE_SEARCH: begin
                  if (any_edge) begin
                     mode_in = MODE_AVOID;
                  end else if (req_ff.target_seen) begin
                     mode_in = MODE_CHARGE;
                  end else if (deadline_ff < req_ff.now_ms) begin
                     phase_in = phase_next;
                     if (phase_next == 2'd0) begin
                        cmd_in      = '{left: MID_L - ROT_DIFF, right: MID_R - ROT_DIFF,
                                        update: 1'b1};
                        deadline_in = turn_deadline;
                     end else if (phase_next == 2'd2) begin
                        cmd_in      = '{left: MID_L + ROT_DIFF, right: MID_R + ROT_DIFF,
                                        update: 1'b1};
                        deadline_in = turn_deadline;
                     end else begin
                        cmd_in      = '{left: STOP, right: FULL, update: 1'b1};
                        deadline_in = req_ff.now_ms + 32'(go_ff);
                     end
                  end
               end
               MODE_CHARGE: begin
                  if (any_edge) begin
                     mode_in = MODE_AVOID;
                  end else if (req_ff.target_seen) begin
                     cmd_in = '{left: STOP, right: FULL, update: 1'b1};
                  end else begin
                     // Start half a sweep back so the first sweep is a half sweep.
                     sweep_start_in = req_ff.now_ms - 32'(period_ff >> 1);
                     mode_in        = MODE_REFIND;
                  end
               end
               MODE_REFIND: begin
                  if (any_edge) begin
                     mode_in = MODE_AVOID;
                  end else if (req_ff.target_seen) begin
                     mode_in = MODE_CHARGE;
                  end else begin
                     diff_in   = req_ff.now_ms - sweep_start_ff;
                     budget_in = BUDGET_W'(limit_ff) * BUDGET_W'(period_ff);
                     state_in  = ST_CMP;
                  end
               end
               MODE_AVOID: begin
                  if (any_edge) begin
                     case (req_ff.edge_bits) inside
                        EDGE_FL, EDGE_FR, EDGE_FRONT:
                           cmd_in = '{left: FULL, right: STOP, update: 1'b1};
                        EDGE_REAR:
                           cmd_in = '{left: STOP, right: FULL, update: 1'b1};
                        EDGE_REAR_FL:
                           cmd_in = '{left: STOP, right: MID_R, update: 1'b1};
                        EDGE_REAR_FR:
                           cmd_in = '{left: MID_L, right: FULL, update: 1'b1};
                        default: ;
                     endcase
                  end else if (req_ff.target_seen) begin
                     mode_in = MODE_CHARGE;
                  end else begin
                     mode_in     = MODE_SEARCH;
                     deadline_in = turn_deadline;
                  end
               end
               default: ;
            endcase
         end
         ST_CMP: begin
            // A zero period gives a zero budget, so the divider never sees it.
            if (diff_ff < 32'(budget_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               mode_in     = MODE_SEARCH;
               deadline_in = turn_deadline;
               state_in    = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_odd) begin
                  cmd_in = '{left: MID_L - ROT_DIFF, right: MID_R - ROT_DIFF, update: 1'b1};
               end else begin
                  cmd_in = '{left: MID_L + ROT_DIFF, right: MID_R + ROT_DIFF, update: 1'b1};
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{left_drive: cmd_ff.left, right_drive: cmd_ff.right,
                                drive_update: cmd_ff.update, mode_code: mode_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= MODE_SEARCH;
         phase_ff       <= 2'd0;
         deadline_ff    <= DEADLINE_RST;
         sweep_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         period_ff      <= SWEEP_PERIOD_RST;
         limit_ff       <= SWEEP_LIMIT_RST;
         turn_ff        <= SEARCH_TURN_RST;
         go_ff          <= SEARCH_GO_RST;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         deadline_ff    <= deadline_in;
         sweep_start_ff <= sweep_start_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SWEEP_PERIOD: period_ff <= csr_data;
               CSR_SWEEP_LIMIT:  limit_ff  <= csr_data[7:0];
               CSR_SEARCH_TURN:  turn_ff   <= csr_data;
               CSR_SEARCH_GO:    go_ff     <= csr_data;
               default: ;
            endcase
         end
      end
      req_ff    <= req_in;
      cmd_ff    <= cmd_in;
      diff_ff   <= diff_in;
      budget_ff <= budget_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised without a finish step");

   a_div_start_cmp: assert property (@(posedge clock) disable iff (reset)
      div_start |-> state_ff == ST_CMP && diff_ff < 32'(budget_ff))
      else $error("divider started without an in-budget sweep");

   a_pending_kept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && rsp_stall |=> state_ff == ST_FINISH)
      else $error("finish step left while the result register was full");

endmodule
